[rtl/core/ibt_pkg.sv]
// Package for the interned bit-set table: sizes, command and status codes,
// and the structs passed between the sequencer and the top level.
// Depends on nothing; ibt_channels, ibt_engine and interned_bitset_table import it.
`default_nettype none

package ibt_pkg;

    // Table geometry.
    localparam int SET_BITS    = 64;
    localparam int TABLE_DEPTH = 64;

    // Fixed field widths of the item channels.
    localparam int CMD_W    = 3;
    localparam int FIELD_W  = 6;
    localparam int STATUS_W = 2;

    // Derived widths.
    localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDXC_W  = (COUNT_W > FIELD_W) ? COUNT_W : FIELD_W;
    localparam int BIT_W   = $clog2(SET_BITS);
    localparam int BITC_W  = $clog2(SET_BITS + 1);
    localparam int ELC_W   = (BITC_W > FIELD_W + 1) ? BITC_W : FIELD_W + 1;

    typedef logic [SET_BITS-1:0] t_set;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [IDXC_W-1:0]   t_idxc;
    typedef logic [BIT_W-1:0]    t_bit;
    typedef logic [ELC_W-1:0]    t_elc;
    typedef logic [FIELD_W-1:0]  t_field;

    // Command codes; the two unused codes are answered with status ST_OK and no table operation.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 3'd0,
        CMD_UNION    = 3'd1,
        CMD_DIFF     = 3'd2,
        CMD_SUBSET   = 3'd3,
        CMD_CONTAINS = 3'd4,
        CMD_NEXT     = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_UNDEF = 2'd2
    } t_status;

    // One input item.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        t_field           first_set;
        t_field           second_set;
        t_field           element_id;
    } t_item;

    // One result item.
    typedef struct packed {
        t_field  result_set;
        logic    flag;
        t_field  found_element;
        t_status status;
    } t_result;

    // Memory access request from the sequencer.
    typedef struct packed {
        logic  rd_en;
        t_addr rd_addr;
        logic  wr_en;
        t_addr wr_addr;
        t_set  wr_data;
    } t_mem_req;

endpackage

`default_nettype wire

[rtl/core/ibt_channels.sv]
// Valid/ready channel interfaces for the command items and the result items.
// Depends on ibt_pkg for the field widths.
`default_nettype none

interface ibt_in_if
    import ibt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [FIELD_W-1:0]  first_set;
    logic [FIELD_W-1:0]  second_set;
    logic [FIELD_W-1:0]  element_id;

    modport source (output valid, command, first_set, second_set, element_id,
                    input ready);
    modport sink   (input valid, command, first_set, second_set, element_id,
                    output ready);
endinterface

interface ibt_out_if
    import ibt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FIELD_W-1:0]  result_set;
    logic                flag;
    logic [FIELD_W-1:0]  found_element;
    logic [STATUS_W-1:0] status;

    modport source (output valid, result_set, flag, found_element, status,
                    input ready);
    modport sink   (input valid, result_set, flag, found_element, status,
                    output ready);
endinterface

`default_nettype wire

[rtl/core/ibt_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module ibt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                          i_wr_data,
    input  wire logic                                      i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/ibt_engine.sv]
// Command sequencer of the interned bit-set table: reads operands from the
// set memory, builds or tests sets, scans the table and appends new sets.
// Depends on ibt_pkg.
`default_nettype none

module ibt_engine
    import ibt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_item_valid,
    output logic          o_item_ready,
    input  wire t_item    i_item,
    output t_mem_req      o_mem,
    input  wire t_set     i_rd_data,
    output logic          o_res_valid,
    input  wire logic     i_res_ready,
    output t_result       o_res
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RDB  = 6'b000010,
        S_OPER = 6'b000100,
        S_NEXT = 6'b001000,
        S_SCAN = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state  r_state, n_state;
    t_item   r_item, n_item;
    t_count  r_count, n_count;
    t_set    r_set_a, n_set_a;
    t_set    r_cand, n_cand;
    t_addr   r_idx, n_idx;
    t_elc    r_bit, n_bit;
    t_result r_res, n_res;

    logic    w_accept;
    logic    w_in_uses_b;
    logic    w_in_undef;
    logic    w_el_ok;
    logic    w_last;

    assign o_item_ready = (r_state == S_IDLE);
    assign w_accept     = i_item_valid && o_item_ready;
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res        = r_res;

    // Index checks on the incoming item.
    assign w_in_uses_b = (i_item.cmd == CMD_UNION) || (i_item.cmd == CMD_DIFF) ||
                         (i_item.cmd == CMD_SUBSET);
    assign w_in_undef  = (i_item.cmd <= CMD_NEXT) &&
                         ((t_idxc'(i_item.first_set) >= t_idxc'(r_count)) ||
                          (w_in_uses_b &&
                           (t_idxc'(i_item.second_set) >= t_idxc'(r_count))));

    // The element lies inside the set width.
    assign w_el_ok = (t_elc'(r_item.element_id) < t_elc'(SET_BITS));

    // The entry being compared is the last defined one.
    assign w_last = ((t_count'(r_idx) + t_count'(1)) == r_count);

    // Next-state and datapath logic.
    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_count = r_count;
        n_set_a = r_set_a;
        n_cand  = r_cand;
        n_idx   = r_idx;
        n_bit   = r_bit;
        n_res   = r_res;
        o_mem   = '0;

        unique case (r_state)
            S_IDLE: begin
                o_mem.rd_en   = w_accept;
                o_mem.rd_addr = t_addr'(i_item.first_set);
                if (w_accept) begin
                    n_item = i_item;
                    n_res  = '{result_set: i_item.first_set, flag: 1'b0,
                              found_element: '0, status: ST_OK};
                    if (w_in_undef) begin
                        n_res.status = ST_UNDEF;
                        n_state      = S_DONE;
                    end else if (i_item.cmd > CMD_NEXT) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RDB;
                    end
                end
            end
            S_RDB: begin
                // First operand arrives; fetch the second.
                n_set_a       = i_rd_data;
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = t_addr'(r_item.second_set);
                n_state       = S_OPER;
            end
            S_OPER: begin
                // Second operand arrives on the read port.
                unique case (t_cmd'(r_item.cmd))
                    CMD_ADD, CMD_UNION, CMD_DIFF: begin
                        if (t_cmd'(r_item.cmd) == CMD_ADD) begin
                            n_cand = r_set_a |
                                     (w_el_ok ? (t_set'(1) << t_bit'(r_item.element_id))
                                              : '0);
                        end else if (t_cmd'(r_item.cmd) == CMD_UNION) begin
                            n_cand = r_set_a | i_rd_data;
                        end else begin
                            n_cand = r_set_a & ~i_rd_data;
                        end
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = '0;
                        n_idx         = '0;
                        n_state       = S_SCAN;
                    end
                    CMD_SUBSET: begin
                        n_res.flag = ((r_set_a & ~i_rd_data) == '0);
                        n_state    = S_DONE;
                    end
                    CMD_CONTAINS: begin
                        n_res.flag = w_el_ok && r_set_a[t_bit'(r_item.element_id)];
                        n_state    = S_DONE;
                    end
                    CMD_NEXT: begin
                        n_bit   = t_elc'(r_item.element_id) + t_elc'(1);
                        n_state = S_NEXT;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_NEXT: begin
                // Test one bit per cycle, upwards from the start point.
                if (r_bit >= t_elc'(SET_BITS)) begin
                    n_state = S_DONE;
                end else if (r_set_a[t_bit'(r_bit)]) begin
                    n_res.found_element = t_field'(r_bit);
                    n_state             = S_DONE;
                end else begin
                    n_bit = r_bit + t_elc'(1);
                end
            end
            S_SCAN: begin
                // Compare one stored set per cycle, lowest index first.
                if (i_rd_data == r_cand) begin
                    n_res.result_set = t_field'(r_idx);
                    n_state          = S_DONE;
                end else if (w_last) begin
                    if (r_count == t_count'(TABLE_DEPTH)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        o_mem.wr_en      = 1'b1;
                        o_mem.wr_addr    = t_addr'(r_count);
                        o_mem.wr_data    = r_cand;
                        n_count          = r_count + t_count'(1);
                        n_res.result_set = t_field'(r_count);
                    end
                    n_state = S_DONE;
                end else begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_idx + t_addr'(1);
                    n_idx         = r_idx + t_addr'(1);
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= t_count'(1);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_set_a <= n_set_a;
        r_cand  <= n_cand;
        r_idx   <= n_idx;
        r_bit   <= n_bit;
        r_res   <= n_res;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= t_count'(TABLE_DEPTH)))
        else $error("entry count out of range");

    a_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.wr_en |-> (r_state == S_SCAN) && !o_mem.rd_en)
        else $error("memory write outside the table scan");

    a_write_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.wr_en |=> (r_count == t_count'($past(r_count) + t_count'(1))))
        else $error("append did not advance the entry count");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (t_count'(r_idx) < r_count))
        else $error("scan index beyond defined entries");
`endif

endmodule

`default_nettype wire

[rtl/core/interned_bitset_table.sv]
// Interned bit-set table: one item in on i_in, one result item out on o_out.
//
// Each command item carries a command, two set indexes and an element. The
// block answers every item with exactly one result item, in order.
// Building commands (add element, union, difference) read their operands,
// then compare the new set with the stored sets one per cycle, lowest index
// first, through the single read port of the set memory; the scan stops at
// the first matching entry, and on a miss they append the set, or report a
// full table. Next element tests one bit per cycle, upwards. A new item is
// taken the cycle after the previous result has moved into the output
// register; one finished result may wait there while the next item is
// already at work, and the block stalls in its last step only when that
// register is still full.
// After reset the table holds only entry 0, the empty set, and no clearing
// pass runs: entry 0 is never written and reads as empty.
// Depends on ibt_pkg, ibt_channels, ibt_ram and ibt_engine.
`default_nettype none

module interned_bitset_table
    import ibt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ibt_in_if.sink    i_in,
    ibt_out_if.source o_out
);

    t_item    w_item;
    t_mem_req w_mem;
    t_set     w_ram_q;
    t_set     w_rd_data;
    t_result  w_res;
    logic     w_res_valid;
    logic     w_res_ready;
    logic     w_item_ready;

    logic     r_rd_zero;
    logic     r_out_valid;
    t_result  r_out;

    assign w_item = '{cmd: i_in.command, first_set: i_in.first_set,
                      second_set: i_in.second_set, element_id: i_in.element_id};
    assign i_in.ready = w_item_ready;

    ibt_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_in.valid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .o_mem        (w_mem),
        .i_rd_data    (w_rd_data),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    ibt_ram #(
        .WIDTH (SET_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_set_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem.wr_en),
        .i_wr_addr (w_mem.wr_addr),
        .i_wr_data (w_mem.wr_data),
        .i_rd_en   (w_mem.rd_en),
        .i_rd_addr (w_mem.rd_addr),
        .o_rd_data (w_ram_q)
    );

    // Entry 0 is the empty set and is never written, so its reads are forced.
    always_ff @(posedge i_clk) begin
        if (w_mem.rd_en) begin
            r_rd_zero <= (w_mem.rd_addr == '0);
        end
    end
    assign w_rd_data = r_rd_zero ? '0 : w_ram_q;

    // Output register: takes a result when empty or being emptied.
    assign w_res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_set    = r_out.result_set;
    assign o_out.flag          = r_out.flag;
    assign o_out.found_element = r_out.found_element;
    assign o_out.status        = r_out.status;

endmodule

`default_nettype wire
